// ----- rtl/rgb_pkg.sv -----
`default_nettype none

package rgb_pkg;

  localparam int IDX_W = 3;
  localparam int OFF_W = 35;
  localparam int SIZE_W = 32;
  localparam int COORD_W = 32;
  localparam int LEN_W = 31;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_LEFT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_TOP = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 8'd3;

  localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 32'd256;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    PH_COL_LO = 2'd0,
    PH_COL_HI = 2'd1,
    PH_ROW_LO = 2'd2,
    PH_ROW_HI = 2'd3
  } phase_t;

  typedef struct packed {
    logic                     start;
    logic signed [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0]        size;
  } idx_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] idx;
  } idx_rsp_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] row_lo;
    logic [IDX_W-1:0] row_hi;
    logic [IDX_W-1:0] col_lo;
    logic [IDX_W-1:0] col_hi;
  } scan_req_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } cell_out_t;

endpackage

`default_nettype wire

// ----- rtl/rgb_idx_unit.sv -----
`default_nettype none

module rgb_idx_unit #(
  parameter int GRID_SIZE = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rgb_pkg::idx_req_t req,
  output rgb_pkg::idx_rsp_t      rsp
);
  import rgb_pkg::*;

  localparam int REM_W = OFF_W + 6;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GRID_SIZE - 1);

  logic              busy_r, busy_nxt;
  logic              neg_r, neg_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [OFF_W-1:0]  acc_r, acc_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [SIZE_W-1:0] size_eff;
  logic              stop;

  // Each step compares the scaled offset against the next multiple of the cell size.
  assign size_eff = (req.size == '0) ? SIZE_W'(1) : req.size;
  assign stop = neg_r || (idx_r == IDX_MAX) || (rem_r < REM_W'(acc_r));

  always_comb begin
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    size_nxt = size_r;
    idx_nxt  = idx_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.offset[OFF_W-1];
      rem_nxt  = {req.offset[OFF_W-3:0], 8'd0};
      acc_nxt  = OFF_W'(size_eff);
      size_nxt = size_eff;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (stop) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        acc_nxt = acc_r + OFF_W'(size_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    size_r <= size_nxt;
    idx_r  <= idx_nxt;
  end

  assign rsp.done = busy_r && stop;
  assign rsp.idx  = idx_r;

endmodule

`default_nettype wire

// ----- rtl/rgb_cell_scan.sv -----
`default_nettype none

module rgb_cell_scan (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rgb_pkg::scan_req_t req,
  output rgb_pkg::cell_out_t      grid_cell
);
  import rgb_pkg::*;

  logic             active_r, active_nxt;
  logic [IDX_W-1:0] row_r, row_nxt;
  logic [IDX_W-1:0] col_r, col_nxt;
  logic [IDX_W-1:0] row_hi_r, row_hi_nxt;
  logic [IDX_W-1:0] col_lo_r, col_lo_nxt;
  logic [IDX_W-1:0] col_hi_r, col_hi_nxt;
  logic             row_end;
  logic             last;

  assign row_end = (col_r == col_hi_r);
  assign last = row_end && (row_r == row_hi_r);

  always_comb begin
    active_nxt = active_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    row_hi_nxt = row_hi_r;
    col_lo_nxt = col_lo_r;
    col_hi_nxt = col_hi_r;
    if (req.start) begin
      active_nxt = 1'b1;
      row_nxt    = req.row_lo;
      col_nxt    = req.col_lo;
      row_hi_nxt = req.row_hi;
      col_lo_nxt = req.col_lo;
      col_hi_nxt = req.col_hi;
    end else if (active_r) begin
      if (last) begin
        active_nxt = 1'b0;
      end else if (row_end) begin
        row_nxt = row_r + IDX_W'(1);
        col_nxt = col_lo_r;
      end else begin
        col_nxt = col_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    row_hi_r <= row_hi_nxt;
    col_lo_r <= col_lo_nxt;
    col_hi_r <= col_hi_nxt;
  end

  assign grid_cell.valid = active_r;
  assign grid_cell.row   = row_r;
  assign grid_cell.col   = col_r;
  assign grid_cell.last  = last;

endmodule

`default_nettype wire

// ----- rtl/rectangle_grid_binning_unit.sv -----
// Channel  Handshake              Payload
// input    start / busy           in_rect_left, in_rect_bottom, in_rect_width, in_rect_height
// output   out_valid (strobe)     out_cell_row, out_cell_col, out_last_cell
// config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item takes four index searches on a shared compare-and-add unit, then emits one cell per
// cycle (1 to GRID_SIZE*GRID_SIZE cells).
// The compare-and-add unit sets the search time, one cell-size multiple per cycle.
// Reset is synchronous and active low; the block comes out of reset idle with default registers.
// The receiver cannot stall; cells leave back to back and busy drops after the last one.
`default_nettype none

module rectangle_grid_binning_unit #(
  parameter int GRID_SIZE = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [rgb_pkg::COORD_W-1:0] in_rect_left,
  input  wire logic signed [rgb_pkg::COORD_W-1:0] in_rect_bottom,
  input  wire logic [rgb_pkg::LEN_W-1:0]        in_rect_width,
  input  wire logic [rgb_pkg::LEN_W-1:0]        in_rect_height,
  output logic                                  out_valid,
  output logic [rgb_pkg::IDX_W-1:0]             out_cell_row,
  output logic [rgb_pkg::IDX_W-1:0]             out_cell_col,
  output logic                                  out_last_cell,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [rgb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rgb_pkg::SIZE_W-1:0]       cfg_data
);
  import rgb_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   kick_r, kick_nxt;

  logic signed [COORD_W-1:0] grid_left_r, grid_top_r;
  logic [SIZE_W-1:0]         cell_width_r, cell_height_r;

  logic signed [COORD_W-1:0] left_r, bottom_r;
  logic [LEN_W-1:0]          width_r, height_r;

  logic [IDX_W-1:0] col_lo_r, col_lo_nxt;
  logic [IDX_W-1:0] col_hi_r, col_hi_nxt;
  logic [IDX_W-1:0] row_lo_r, row_lo_nxt;

  logic signed [OFF_W-1:0] term_a, term_b, term_len, offset;
  logic                    accept;

  idx_req_t  idx_req;
  idx_rsp_t  idx_rsp;
  scan_req_t scan_req;
  cell_out_t scan_cell;

  assign cfg_ready = 1'b1;
  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_left_r   <= '0;
      grid_top_r    <= '0;
      cell_width_r  <= CELL_SIZE_RESET;
      cell_height_r <= CELL_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_LEFT:   grid_left_r   <= cfg_data;
        CFG_GRID_TOP:    grid_top_r    <= cfg_data;
        CFG_CELL_WIDTH:  cell_width_r  <= cfg_data;
        CFG_CELL_HEIGHT: cell_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_r   <= in_rect_left;
      bottom_r <= in_rect_bottom;
      width_r  <= in_rect_width;
      height_r <= in_rect_height;
    end
  end

  always_comb begin
    term_a   = OFF_W'(grid_top_r);
    term_b   = OFF_W'(bottom_r);
    term_len = '0;
    case (phase_r)
      PH_COL_LO: begin
        term_a = OFF_W'(left_r);
        term_b = OFF_W'(grid_left_r);
      end
      PH_COL_HI: begin
        term_a   = OFF_W'(left_r);
        term_b   = OFF_W'(grid_left_r);
        term_len = $signed({(OFF_W - LEN_W)'(0), width_r});
      end
      PH_ROW_LO: begin
        term_len = -$signed({(OFF_W - LEN_W)'(0), height_r});
      end
      PH_ROW_HI: begin
        term_len = '0;
      end
      default: ;
    endcase
    offset = term_a - term_b + term_len;
  end

  assign idx_req.start  = kick_r;
  assign idx_req.offset = offset;
  assign idx_req.size   = (phase_r == PH_COL_LO || phase_r == PH_COL_HI) ?
                          cell_width_r : cell_height_r;

  rgb_idx_unit #(
    .GRID_SIZE(GRID_SIZE)
  ) u_idx (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (idx_req),
    .rsp  (idx_rsp)
  );

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    kick_nxt   = 1'b0;
    col_lo_nxt = col_lo_r;
    col_hi_nxt = col_hi_r;
    row_lo_nxt = row_lo_r;
    scan_req.start  = 1'b0;
    scan_req.row_lo = row_lo_r;
    scan_req.row_hi = idx_rsp.idx;
    scan_req.col_lo = col_lo_r;
    scan_req.col_hi = col_hi_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CALC;
          phase_nxt = PH_COL_LO;
          kick_nxt  = 1'b1;
        end
      end
      ST_CALC: begin
        if (idx_rsp.done) begin
          case (phase_r)
            PH_COL_LO: col_lo_nxt = idx_rsp.idx;
            PH_COL_HI: col_hi_nxt = idx_rsp.idx;
            PH_ROW_LO: row_lo_nxt = idx_rsp.idx;
            default: ;
          endcase
          if (phase_r == PH_ROW_HI) begin
            state_nxt = ST_SCAN;
            scan_req.start = 1'b1;
          end else begin
            phase_nxt = phase_t'(phase_r + 2'd1);
            kick_nxt  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (scan_cell.valid && scan_cell.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_COL_LO;
      kick_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      kick_r  <= kick_nxt;
    end
    col_lo_r <= col_lo_nxt;
    col_hi_r <= col_hi_nxt;
    row_lo_r <= row_lo_nxt;
  end

  rgb_cell_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (scan_req),
    .grid_cell(scan_cell)
  );

  assign out_valid     = scan_cell.valid;
  assign out_cell_row  = scan_cell.row;
  assign out_cell_col  = scan_cell.col;
  assign out_last_cell = scan_cell.last;

endmodule

`default_nettype wire

// ----- rtl/rgb_checker.sv -----
`default_nettype none

module rgb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last_cell
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_out_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("item emitted while idle");

  a_cells_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_cell |=> out_valid)
    else $error("gap inside a rectangle's cell sequence");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_cell |=> !out_valid && !busy)
    else $error("activity after the last cell");

endmodule

bind rectangle_grid_binning_unit rgb_checker u_rgb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_last_cell(out_last_cell)
);

`default_nettype wire

// ----- tb/rgb_binning_checker.sv -----
`timescale 1ns / 1ps

module rgb_binning_checker #(
  parameter int GRID_SIZE = 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic                                busy,
  input  wire logic signed [rgb_pkg::COORD_W-1:0]  rect_left,
  input  wire logic signed [rgb_pkg::COORD_W-1:0]  rect_bottom,
  input  wire logic [rgb_pkg::LEN_W-1:0]           rect_width,
  input  wire logic [rgb_pkg::LEN_W-1:0]           rect_height,
  input  wire logic                                out_valid,
  input  wire logic [rgb_pkg::IDX_W-1:0]           cell_row,
  input  wire logic [rgb_pkg::IDX_W-1:0]           cell_col,
  input  wire logic                                last_cell,
  input  wire logic                                cfg_valid,
  input  wire logic                                cfg_ready,
  input  wire logic [rgb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rgb_pkg::SIZE_W-1:0]          cfg_data,
  output int                                       mismatches,
  output int                                       cells_pending
);
  import rgb_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } cell_t;

  cell_t                     expected_cells[$];
  logic signed [COORD_W-1:0] grid_left = '0;
  logic signed [COORD_W-1:0] grid_top = '0;
  logic [SIZE_W-1:0]         cell_width = CELL_SIZE_RESET;
  logic [SIZE_W-1:0]         cell_height = CELL_SIZE_RESET;

  initial begin
    mismatches = 0;
    cells_pending = 0;
  end

  function automatic logic [IDX_W-1:0] bin_of(longint offset, logic [SIZE_W-1:0] size);
    longint unsigned divisor;
    longint unsigned scaled;
    longint unsigned quotient;
    divisor = (size == '0) ? 64'd1 : {32'd0, size};
    if (offset < 0) begin
      return '0;
    end
    scaled = offset;
    quotient = (scaled * 64'd256) / divisor;
    if (quotient >= GRID_SIZE) begin
      return IDX_W'(GRID_SIZE - 1);
    end
    return IDX_W'(quotient);
  endfunction

  task automatic bin_rectangle();
    longint           left;
    longint           bottom;
    longint           right_edge;
    longint           top_edge;
    longint           box_left;
    longint           box_top;
    logic [IDX_W-1:0] col_lo;
    logic [IDX_W-1:0] col_hi;
    logic [IDX_W-1:0] row_lo;
    logic [IDX_W-1:0] row_hi;
    cell_t            entry;
    left = rect_left;
    bottom = rect_bottom;
    box_left = grid_left;
    box_top = grid_top;
    right_edge = left + longint'({1'b0, rect_width});
    top_edge = bottom + longint'({1'b0, rect_height});
    col_lo = bin_of(left - box_left, cell_width);
    col_hi = bin_of(right_edge - box_left, cell_width);
    row_lo = bin_of(box_top - top_edge, cell_height);
    row_hi = bin_of(box_top - bottom, cell_height);
    for (int r = int'(row_lo); r <= int'(row_hi); r++) begin
      for (int c = int'(col_lo); c <= int'(col_hi); c++) begin
        entry.row = IDX_W'(r);
        entry.col = IDX_W'(c);
        entry.last = (r == int'(row_hi)) && (c == int'(col_hi));
        expected_cells.insert(expected_cells.size(), entry);
      end
    end
  endtask

  task automatic flag(string msg);
    if (mismatches < 10) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    cell_t seen;
    cell_t want;
    if (!rst_n) begin
      grid_left = '0;
      grid_top = '0;
      cell_width = CELL_SIZE_RESET;
      cell_height = CELL_SIZE_RESET;
      expected_cells.delete();
    end else begin
      if (out_valid) begin
        seen = '{cell_row, cell_col, last_cell};
        if (expected_cells.size() == 0) begin
          flag($sformatf("unexpected cell row %0d col %0d last %0b",
                         seen.row, seen.col, seen.last));
        end else begin
          want = expected_cells.pop_front();
          if (seen !== want) begin
            flag($sformatf("expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                           want.row, want.col, want.last, seen.row, seen.col, seen.last));
          end
        end
      end
      if (start && !busy) begin
        bin_rectangle();
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_GRID_LEFT: grid_left = cfg_data;
          CFG_GRID_TOP: grid_top = cfg_data;
          CFG_CELL_WIDTH: cell_width = cfg_data;
          CFG_CELL_HEIGHT: cell_height = cfg_data;
          default: ;
        endcase
      end
    end
    cells_pending <= expected_cells.size();
  end

endmodule

// ----- tb/tb_rectangle_grid_binning_unit.sv -----
`timescale 1ns / 1ps

module tb_rectangle_grid_binning_unit;
  import rgb_pkg::*;

  localparam int GRID_SIZE = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'd4;
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] in_rect_left = '0;
  logic signed [COORD_W-1:0] in_rect_bottom = '0;
  logic [LEN_W-1:0]          in_rect_width = '0;
  logic [LEN_W-1:0]          in_rect_height = '0;
  logic                      out_valid;
  logic [IDX_W-1:0]          out_cell_row;
  logic [IDX_W-1:0]          out_cell_col;
  logic                      out_last_cell;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [SIZE_W-1:0]         cfg_data = '0;
  int                        mismatches;
  int                        cells_pending;
  int                        idle_cycles = 0;
  int                        burst_left = 1;

  logic signed [COORD_W-1:0] box_left = '0;
  logic signed [COORD_W-1:0] box_top = '0;
  logic [SIZE_W-1:0]         box_cell_w = CELL_SIZE_RESET;
  logic [SIZE_W-1:0]         box_cell_h = CELL_SIZE_RESET;

  rectangle_grid_binning_unit #(
    .GRID_SIZE(GRID_SIZE)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_rect_left(in_rect_left),
    .in_rect_bottom(in_rect_bottom),
    .in_rect_width(in_rect_width),
    .in_rect_height(in_rect_height),
    .out_valid(out_valid),
    .out_cell_row(out_cell_row),
    .out_cell_col(out_cell_col),
    .out_last_cell(out_last_cell),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  rgb_binning_checker #(
    .GRID_SIZE(GRID_SIZE)
  ) checker_i (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .rect_left(in_rect_left),
    .rect_bottom(in_rect_bottom),
    .rect_width(in_rect_width),
    .rect_height(in_rect_height),
    .out_valid(out_valid),
    .cell_row(out_cell_row),
    .cell_col(out_cell_col),
    .last_cell(out_last_cell),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .cells_pending(cells_pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [SIZE_W-1:0] data);
    cfg_index <= index;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_grid(logic signed [COORD_W-1:0] left, logic signed [COORD_W-1:0] top,
                          logic [SIZE_W-1:0] cell_w, logic [SIZE_W-1:0] cell_h);
    box_left = left;
    box_top = top;
    box_cell_w = cell_w;
    box_cell_h = cell_h;
    write_reg(CFG_GRID_LEFT, left);
    write_reg(CFG_GRID_TOP, top);
    write_reg(CFG_CELL_WIDTH, cell_w);
    write_reg(CFG_CELL_HEIGHT, cell_h);
  endtask

  task automatic send_rect(logic signed [COORD_W-1:0] left, logic signed [COORD_W-1:0] bottom,
                           logic [LEN_W-1:0] width, logic [LEN_W-1:0] height);
    int gap;
    in_rect_left <= left;
    in_rect_bottom <= bottom;
    in_rect_width <= width;
    in_rect_height <= height;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0 || busy) @(posedge clk);
  endtask

  task automatic random_grid();
    logic [SIZE_W-1:0] cell_w;
    logic [SIZE_W-1:0] cell_h;
    if ($urandom_range(0, 3) == 0) begin
      set_grid($urandom, $urandom, $urandom, $urandom);
    end else begin
      cell_w = $urandom_range(1, 1 << $urandom_range(1, 16));
      cell_h = $urandom_range(1, 1 << $urandom_range(1, 16));
      set_grid($urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000,
               $urandom_range(0, 32'h1FFF_FFFF) - 32'h1000_0000, cell_w, cell_h);
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg($urandom_range(CFG_SPARE, 255), $urandom);
    end
  endtask

  task automatic random_rect();
    longint span_x;
    longint span_y;
    longint ox;
    longint oy;
    longint w;
    longint h;
    longint left;
    longint bottom;
    if ($urandom_range(0, 4) == 0) begin
      send_rect($urandom, $urandom, $urandom, $urandom);
    end else begin
      span_x = (longint'(box_cell_w) * GRID_SIZE) / 256 + 1;
      span_y = (longint'(box_cell_h) * GRID_SIZE) / 256 + 1;
      ox = longint'($urandom_range(0, span_x * 5 / 4)) - span_x / 8;
      oy = longint'($urandom_range(0, span_y * 5 / 4)) - span_y / 8;
      w = $urandom_range(0, ($urandom_range(0, 3) == 0) ? span_x * 2 : span_x / 3);
      h = $urandom_range(0, ($urandom_range(0, 3) == 0) ? span_y * 2 : span_y / 3);
      left = longint'(box_left) + ox;
      bottom = longint'(box_top) - oy - h;
      send_rect(left[COORD_W-1:0], bottom[COORD_W-1:0], w[LEN_W-1:0], h[LEN_W-1:0]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_rect(0, -1, 0, 0);
    send_rect(0, -7, 7, 7);
    send_rect(2, -3, 1, 0);
    send_rect(COORD_MIN, COORD_MIN, LEN_MAX, LEN_MAX);
    send_rect(COORD_MAX, COORD_MAX, LEN_MAX, LEN_MAX);
    send_rect(-100, 100, 0, 0);
    wait_idle();

    set_grid(COORD_MIN, COORD_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_rect(COORD_MAX, COORD_MIN, LEN_MAX, 0);
    send_rect(COORD_MIN, COORD_MAX, 0, LEN_MAX);
    send_rect(-1, 0, 0, 1);
    wait_idle();

    // Zero cell sizes act as the smallest size; spare register indexes are ignored.
    set_grid(COORD_MAX, COORD_MIN, 0, 0);
    write_reg(CFG_SPARE, 32'd256);
    write_reg(8'hFF, 32'hFFFF_FFFF);
    send_rect(COORD_MAX, COORD_MIN, 0, 0);
    send_rect(COORD_MAX, COORD_MIN, 1, 5);
    send_rect(COORD_MIN, 0, LEN_MAX, 0);
    wait_idle();

    set_grid(-40, 24, 32'd1280, 32'd768);
    send_rect(-40, 0, 40, 24);
    send_rect(-35, 18, 0, 0);
    send_rect(-36, 12, 3, 2);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      random_grid();
      repeat (ITEMS_PER_PHASE) random_rect();
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && cells_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rgb_pkg.sv
rtl/rgb_idx_unit.sv
rtl/rgb_cell_scan.sv
rtl/rectangle_grid_binning_unit.sv
rtl/rgb_checker.sv
tb/rgb_binning_checker.sv
tb/tb_rectangle_grid_binning_unit.sv
